// ===== rtl/lrut_pkg.sv =====
// Shared types and constants of the lazy range-update / range-query tree.
// Used by the top level (entry, entry width, states), not by lrut_ram.
`default_nettype none
package lrut_pkg;

  localparam int LRUT_LEAVES = 1024;
  localparam int AGG_W       = 48;
  localparam int STAMP_W     = 32;

  localparam logic [AGG_W-1:0] MIN_IDENT = 48'h0000_7FFF_FFFF;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_REBUILD = 2'd1,
    REQ_UPDATE  = 2'd2,
    REQ_QUERY   = 2'd3
  } lrut_req_t;

  localparam logic CFG_UPDATE_MODE  = 1'b0;
  localparam logic CFG_COMBINE_MODE = 1'b1;

  // One tree node as held in memory.
  typedef struct packed {
    logic [AGG_W-1:0]   amt;
    logic [STAMP_W-1:0] stamp;
    logic [AGG_W-1:0]   agg;
  } lrut_entry_t;

  localparam int ENTRY_W = $bits(lrut_entry_t);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_RB_A,
    ST_RB_B,
    ST_RB_C,
    ST_RB_D,
    ST_VIS_A,
    ST_VIS_B,
    ST_PL,
    ST_PR_A,
    ST_PR,
    ST_DEC,
    ST_RET,
    ST_OUT
  } lrut_state_t;

endpackage
`default_nettype wire

// ===== rtl/lazy_range_update_query_tree_top.sv =====
// Top level of the lazy segment tree: request sequencer and node datapath.
// Depends on lrut_pkg and on lrut_ram, which holds every tree node.
`default_nettype none
// One request is taken at a time. The tree lives in a single-port RAM of
// 2*LEAVES entries (LEAVES rounded up to a power of two), each node holding
// its aggregate and its pending tag; nodes are read and written back through
// the one port, so the RAM port sets the rate. A load reads the leaf and
// writes it back; a range update or query walks down from the root and back
// up, visiting at most about 4 nodes per level and pushing pending tags to
// the children on its way; a rebuild recombines each internal node from its
// two children. After reset and after each write of combine_mode the block
// sweeps every RAM entry to restore the identity and takes no request meanwhile.
module lazy_range_update_query_tree_top #(
  parameter int LEAVES = lrut_pkg::LRUT_LEAVES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // index_lo[9:0], index_hi[20:10], value[52:21]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // result_value[47:0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);
  import lrut_pkg::*;

  localparam int LOG  = $clog2(LEAVES);
  localparam int SIZE = 1 << LOG;
  localparam int AW   = LOG + 1;
  localparam int DW   = $clog2(LOG + 1);
  localparam int CW   = (LOG + 1 > 11) ? LOG + 1 : 11;
  localparam logic [DW-1:0] LOG_D = DW'(LOG);

  lrut_state_t state_r, state_nxt;

  logic               upd_mode_r, cmb_mode_r;
  logic [STAMP_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]         req_r, req_nxt;
  logic [9:0]         lo_r, lo_nxt;
  logic [10:0]        hi_r, hi_nxt;
  logic [AGG_W-1:0]   val_r, val_nxt;
  logic [AW-1:0]      k_r, k_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic [AGG_W-1:0]   pa_r, pa_nxt;
  logic [STAMP_W-1:0] ts_r, ts_nxt;
  logic [AGG_W-1:0]   ta_r, ta_nxt;
  logic [AGG_W-1:0]   ret_r, ret_nxt;
  logic [AGG_W-1:0]   tmp_r, tmp_nxt;
  logic [AGG_W-1:0]   left_r [LOG+1];
  logic               left_we;
  logic [AGG_W-1:0]   left_wdata;
  logic               out_valid_r, out_valid_nxt;
  logic [AGG_W-1:0]   out_data_r, out_data_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  lrut_entry_t        ram_wdata, ram_rdata;

  logic [AGG_W-1:0]   ident;
  logic [CW-1:0]      node_l, node_r, node_len, lo_x, hi_x, kmask;
  logic [DW-1:0]      sh;
  logic               internal, disjoint, full, tnz, upd_req;
  logic               in_acc;
  logic [AW-1:0]      k_left, k_right;

  lrut_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 * SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  function automatic logic [AGG_W-1:0] f_combine(input logic cm,
                                                 input logic [AGG_W-1:0] a,
                                                 input logic [AGG_W-1:0] b);
    logic [AGG_W-1:0] res;
    if (!cm) begin
      res = a + b;
    end else begin
      res = ($signed(a) <= $signed(b)) ? a : b;
    end
    return res;
  endfunction

  function automatic logic [AGG_W-1:0] f_apply(input logic um, input logic cm,
                                               input logic [AGG_W-1:0] agg,
                                               input logic [STAMP_W-1:0] st,
                                               input logic [AGG_W-1:0] amt,
                                               input logic [DW-1:0] s);
    logic [AGG_W-1:0] eff;
    logic [AGG_W-1:0] res;
    eff = cm ? amt : (amt << s);
    if (!um) begin
      res = agg + eff;
    end else begin
      res = (st != '0) ? eff : agg;
    end
    return res;
  endfunction

  function automatic lrut_entry_t f_merge(input logic um, input lrut_entry_t e,
                                          input logic [STAMP_W-1:0] st,
                                          input logic [AGG_W-1:0] amt);
    lrut_entry_t res;
    res = e;
    if (!um) begin
      if (st > e.stamp) begin
        res.stamp = st;
      end
      res.amt = e.amt + amt;
    end else if (!(e.stamp > st)) begin
      res.stamp = st;
      res.amt   = amt;
    end
    return res;
  endfunction

  assign ident   = cmb_mode_r ? MIN_IDENT : '0;
  assign upd_req = (req_r == REQ_UPDATE);
  assign in_acc  = in_tvalid && in_tready;

  // Segment [node_l, node_r) covered by node k_r at depth depth_r.
  assign sh       = LOG_D - depth_r;
  assign kmask    = (CW'(1) << depth_r) - CW'(1);
  assign node_l   = (CW'(k_r) & kmask) << sh;
  assign node_len = CW'(1) << sh;
  assign node_r   = node_l + node_len;
  assign lo_x     = CW'(lo_r);
  assign hi_x     = CW'(hi_r);
  assign disjoint = (node_r <= lo_x) || (hi_x <= node_l);
  assign full     = (lo_x <= node_l) && (node_r <= hi_x);
  assign internal = (depth_r != LOG_D);
  assign tnz      = (ram_rdata.stamp != '0) || (ram_rdata.amt != '0);
  assign k_left   = {k_r[AW-2:0], 1'b0};
  assign k_right  = {k_r[AW-2:0], 1'b1};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (k_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_LOAD:    state_nxt = ST_LD_RD;
            REQ_REBUILD: state_nxt = ST_RB_A;
            default:     state_nxt = ST_VIS_A;
          endcase
        end
      end
      ST_LD_RD: state_nxt = (CW'(lo_r) < CW'(SIZE)) ? ST_LD_WR : ST_OUT;
      ST_LD_WR: state_nxt = ST_OUT;
      ST_RB_A:  state_nxt = ST_RB_B;
      ST_RB_B:  state_nxt = ST_RB_C;
      ST_RB_C:  state_nxt = ST_RB_D;
      ST_RB_D:  state_nxt = (k_r == AW'(1)) ? ST_OUT : ST_RB_A;
      ST_VIS_A: state_nxt = ST_VIS_B;
      ST_VIS_B: state_nxt = (tnz && internal) ? ST_PL : ST_DEC;
      ST_PL:    state_nxt = ST_PR_A;
      ST_PR_A:  state_nxt = ST_PR;
      ST_PR:    state_nxt = ST_DEC;
      ST_DEC:   state_nxt = (!disjoint && !full) ? ST_VIS_A : ST_RET;
      ST_RET: begin
        if (depth_r == '0) begin
          state_nxt = ST_OUT;
        end else if (!k_r[0]) begin
          state_nxt = ST_VIS_A;
        end
      end
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLR;
    endcase
    if (cfg_we && cfg_index == CFG_COMBINE_MODE) begin
      state_nxt = ST_CLR;
    end
  end

  // Memory control and datapath.
  always_comb begin
    lrut_entry_t e;
    e          = ram_rdata;
    ram_we     = 1'b0;
    ram_addr   = k_r;
    ram_wdata  = e;
    cnt_nxt    = cnt_r;
    req_nxt    = req_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    val_nxt    = val_r;
    k_nxt      = k_r;
    depth_nxt  = depth_r;
    pa_nxt     = pa_r;
    ts_nxt     = ts_r;
    ta_nxt     = ta_r;
    ret_nxt    = ret_r;
    tmp_nxt    = tmp_r;
    left_we    = 1'b0;
    left_wdata = ret_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '{amt: '0, stamp: '0, agg: ident};
        k_nxt     = k_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_tuser;
          lo_nxt    = in_tdata[9:0];
          hi_nxt    = in_tdata[20:10];
          val_nxt   = {{(AGG_W-32){in_tdata[52]}}, in_tdata[52:21]};
          ret_nxt   = '0;
          depth_nxt = '0;
          k_nxt     = AW'(1);
          if (in_tuser == REQ_LOAD) begin
            k_nxt = AW'(SIZE) | AW'(in_tdata[9:0]);
          end else if (in_tuser == REQ_REBUILD) begin
            k_nxt = AW'(SIZE - 1);
          end else if (in_tuser == REQ_UPDATE) begin
            cnt_nxt = (cnt_r == '1) ? STAMP_W'(1) : cnt_r + STAMP_W'(1);
          end
        end
      end
      ST_LD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{amt: e.amt, stamp: e.stamp, agg: val_r};
      end
      ST_RB_A: ram_addr = k_left;
      ST_RB_B: begin
        tmp_nxt  = e.agg;
        ram_addr = k_right;
      end
      ST_RB_C: begin
        tmp_nxt = f_combine(cmb_mode_r, tmp_r, e.agg);
      end
      ST_RB_D: begin
        ram_we    = 1'b1;
        ram_wdata = '{amt: e.amt, stamp: e.stamp, agg: tmp_r};
        k_nxt     = k_r - AW'(1);
      end
      ST_VIS_B: begin
        // Push the pending tag into this node; children get it next.
        pa_nxt = tnz ? f_apply(upd_mode_r, cmb_mode_r, e.agg, e.stamp, e.amt, sh) : e.agg;
        ts_nxt = e.stamp;
        ta_nxt = e.amt;
        if (tnz && internal) begin
          ram_addr = k_left;
        end
      end
      ST_PL: begin
        ram_we    = 1'b1;
        ram_addr  = k_left;
        ram_wdata = f_merge(upd_mode_r, e, ts_r, ta_r);
      end
      ST_PR_A: ram_addr = k_right;
      ST_PR: begin
        ram_we    = 1'b1;
        ram_addr  = k_right;
        ram_wdata = f_merge(upd_mode_r, e, ts_r, ta_r);
      end
      ST_DEC: begin
        ram_we    = 1'b1;
        ram_wdata = '{amt: '0, stamp: '0, agg: pa_r};
        if (disjoint) begin
          ret_nxt = upd_req ? pa_r : ident;
        end else if (full) begin
          if (upd_req) begin
            ram_wdata = '{amt: val_r, stamp: cnt_r, agg: pa_r};
            ret_nxt   = f_apply(upd_mode_r, cmb_mode_r, pa_r, cnt_r, val_r, sh);
          end else begin
            ret_nxt = pa_r;
          end
        end else begin
          k_nxt     = k_left;
          depth_nxt = depth_r + DW'(1);
        end
      end
      ST_RET: begin
        if (depth_r == '0) begin
          ret_nxt = ret_r;
        end else if (!k_r[0]) begin
          // Left child done: hold its result, descend into the right one.
          left_we = 1'b1;
          k_nxt   = k_r + AW'(1);
        end else begin
          ret_nxt   = f_combine(cmb_mode_r, left_r[depth_r], ret_r);
          k_nxt     = k_r >> 1;
          depth_nxt = depth_r - DW'(1);
          ram_addr  = k_r >> 1;
          ram_we    = upd_req;
          ram_wdata = '{amt: '0, stamp: '0, agg: ret_nxt};
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ret_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    if (cfg_we && cfg_index == CFG_COMBINE_MODE) begin
      k_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      k_r         <= '0;
      upd_mode_r  <= 1'b0;
      cmb_mode_r  <= 1'b0;
      cnt_r       <= STAMP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_UPDATE_MODE) begin
        upd_mode_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_COMBINE_MODE) begin
        cmb_mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    val_r      <= val_nxt;
    depth_r    <= depth_nxt;
    pa_r       <= pa_nxt;
    ts_r       <= ts_nxt;
    ta_r       <= ta_nxt;
    ret_r      <= ret_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
    if (left_we) begin
      left_r[depth_r] <= left_wdata;
    end
  end

`ifndef ASSERT_OFF
  a_clr_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_tready)
    else $error("request accepted during clearing sweep");

  a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VIS_A || state_r == ST_DEC) |-> (k_r != '0 && depth_r <= LOG_D))
    else $error("tree walk left the node range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_we) |=> !in_tready)
    else $error("second request taken while one is in progress");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_tready) && !cfg_we) |=> out_tvalid)
    else $error("finished result not presented");
`endif

endmodule
`default_nettype wire

// ===== rtl/lrut_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module lrut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
